// ===== rtl/kcp_pkg.sv =====
// Package for the kernel convolution propagation block: widths, register
// indexes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package kcp_pkg;

  localparam int MAX_TAPS  = 256;
  localparam int TAP_W     = $clog2(MAX_TAPS);
  localparam int CNT_W     = $clog2(MAX_TAPS + 1);

  localparam int ACTIVE_W  = 9;
  localparam int TS_W      = 16;
  localparam int TS_BIT_W  = $clog2(TS_W);
  localparam int IDX_W     = 8;
  localparam int COEF_W    = 24;
  localparam int SAMPLE_W  = 32;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam int FRAC_DROP = 23;
  localparam int PROD_W    = COEF_W + 1 + SAMPLE_W;
  localparam int ACC_W     = PROD_W + TAP_W;
  localparam int SCL_W     = ACC_W + TS_W;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(256);
  localparam logic [TS_W-1:0]     TS_RESET     = TS_W'(60);

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TAPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 1'b1;

  // Request codes.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic load_kernel;
    logic store_sample;
    logic issue;
    logic scale_init;
    logic scale_step;
    logic out_load;
  } kcp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic last_issue;
    logic pipe_busy;
    logic scale_last;
  } kcp_stat_t;

endpackage

// ===== rtl/kcp_ctrl.sv =====
// Controller of the kernel convolution block: sequences the tap loop, the
// time-step scaling and the output word. Depends on kcp_pkg.
`timescale 1ns / 1ps

module kcp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  kcp_pkg::kcp_stat_t stat_i,
  output kcp_pkg::kcp_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == kcp_pkg::REQ_SAMPLE) begin
            cmd_o.store_sample = 1'b1;
            state_d            = ST_MAC;
          end else begin
            cmd_o.load_kernel = 1'b1;
          end
        end
      end
      ST_MAC: begin
        cmd_o.issue = !stat_i.n_zero;
        if (stat_i.n_zero || stat_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Wait until the last product has reached the accumulator.
        if (!stat_i.pipe_busy) begin
          cmd_o.scale_init = 1'b1;
          state_d          = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale_step = 1'b1;
        if (stat_i.scale_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/kcp_datapath.sv =====
// Datapath of the kernel convolution block: configuration registers, kernel
// and history memories, multiply-accumulate pipeline, shift-add time-step
// scaling and the saturating output register. Depends on kcp_pkg.
`timescale 1ns / 1ps

module kcp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kcp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [kcp_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic [kcp_pkg::IDX_W-1:0]           tap_index_i,
  input  logic [kcp_pkg::COEF_W-1:0]          coefficient_i,
  input  logic signed [kcp_pkg::SAMPLE_W-1:0] flow_sample_i,
  input  kcp_pkg::kcp_cmd_t                   cmd_i,
  output kcp_pkg::kcp_stat_t                  stat_o,
  output logic signed [kcp_pkg::OUT_W-1:0]    flow_out_o,
  output logic                                saturated_o
);

  localparam int TAP_W = kcp_pkg::TAP_W;
  localparam int CNT_W = kcp_pkg::CNT_W;

  // Configuration.
  logic [kcp_pkg::ACTIVE_W-1:0] active_q;
  logic [kcp_pkg::TS_W-1:0]     ts_q;

  // Memories.
  logic [kcp_pkg::COEF_W-1:0]   kernel_mem [kcp_pkg::MAX_TAPS];
  logic [kcp_pkg::SAMPLE_W-1:0] hist_mem   [kcp_pkg::MAX_TAPS];
  logic [kcp_pkg::COEF_W-1:0]   kdata_q;
  logic [kcp_pkg::SAMPLE_W-1:0] hdata_q;

  // Sample bookkeeping and loop.
  logic [CNT_W-1:0] count_q;
  logic [TAP_W-1:0] wp_q;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] idx_q;
  logic [TAP_W-1:0] haddr_q;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] n_d;
  logic             kernel_we;

  // Arithmetic.
  logic                               rd_vld_q, mul_vld_q;
  logic signed [kcp_pkg::PROD_W-1:0]  prod_q;
  logic signed [kcp_pkg::ACC_W-1:0]   acc_q;
  logic signed [kcp_pkg::SCL_W-1:0]   scl_q, scl_d;
  logic [kcp_pkg::TS_BIT_W-1:0]       bit_q;
  logic [kcp_pkg::SCL_W-1:kcp_pkg::FRAC_DROP+kcp_pkg::OUT_W-1] scl_hi;
  logic                               fits;
  logic [kcp_pkg::OUT_W-1:0]          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= kcp_pkg::ACTIVE_RESET;
      ts_q     <= kcp_pkg::TS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kcp_pkg::REG_ACTIVE_TAPS: active_q <= cfg_wdata_i[kcp_pkg::ACTIVE_W-1:0];
        kcp_pkg::REG_TIME_STEP:   ts_q     <= cfg_wdata_i[kcp_pkg::TS_W-1:0];
        default: ;
      endcase
    end
  end

  assign kernel_we = cmd_i.load_kernel &&
                     (32'(tap_index_i) < 32'(kcp_pkg::MAX_TAPS));

  always_ff @(posedge clk_i) begin
    if (kernel_we) begin
      kernel_mem[TAP_W'(tap_index_i)] <= coefficient_i;
    end
    if (cmd_i.issue) begin
      kdata_q <= kernel_mem[idx_q[TAP_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_sample) begin
      hist_mem[wp_q] <= flow_sample_i;
    end
    if (cmd_i.issue) begin
      hdata_q <= hist_mem[haddr_q];
    end
  end

  // Number of terms: previous samples, limited by the active tap count.
  assign lim = (32'(active_q) > 32'(kcp_pkg::MAX_TAPS)) ?
               CNT_W'(kcp_pkg::MAX_TAPS) : CNT_W'(active_q);
  assign n_d = (count_q < lim) ? count_q : lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wp_q    <= '0;
      n_q     <= '0;
      idx_q   <= '0;
      haddr_q <= '0;
    end else if (cmd_i.store_sample) begin
      n_q     <= n_d;
      idx_q   <= '0;
      haddr_q <= wp_q;
      if (32'(count_q) < 32'(kcp_pkg::MAX_TAPS)) begin
        count_q <= count_q + CNT_W'(1);
      end
      wp_q <= (32'(wp_q) == 32'(kcp_pkg::MAX_TAPS - 1)) ? '0 : wp_q + TAP_W'(1);
    end else if (cmd_i.issue) begin
      idx_q   <= idx_q + CNT_W'(1);
      haddr_q <= (haddr_q == '0) ? TAP_W'(kcp_pkg::MAX_TAPS - 1) : haddr_q - TAP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.issue;
      mul_vld_q <= rd_vld_q;
    end
  end

  // Coefficient is unsigned, so it gets a zero sign bit before the multiply.
  always_ff @(posedge clk_i) begin
    prod_q <= $signed({1'b0, kdata_q}) * $signed(hdata_q);
    if (cmd_i.store_sample) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + kcp_pkg::ACC_W'(prod_q);
    end
  end

  // Most significant bit of the time step first: shift, then add.
  assign scl_d = (scl_q <<< 1) +
                 (ts_q[bit_q] ? kcp_pkg::SCL_W'(acc_q) : kcp_pkg::SCL_W'(0));

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_init) begin
      scl_q <= '0;
      bit_q <= kcp_pkg::TS_BIT_W'(kcp_pkg::TS_W - 1);
    end else if (cmd_i.scale_step) begin
      scl_q <= scl_d;
      bit_q <= bit_q - kcp_pkg::TS_BIT_W'(1);
    end
  end

  // An arithmetic shift right floors; the result fits when all bits above
  // the output window equal its sign.
  assign scl_hi = scl_q[kcp_pkg::SCL_W-1:kcp_pkg::FRAC_DROP+kcp_pkg::OUT_W-1];
  assign fits   = (scl_hi == '0) || (scl_hi == '1);
  assign res    = fits ? scl_q[kcp_pkg::FRAC_DROP+kcp_pkg::OUT_W-1:kcp_pkg::FRAC_DROP] :
                  (scl_q[kcp_pkg::SCL_W-1] ? kcp_pkg::OUT_MIN : kcp_pkg::OUT_MAX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      flow_out_o  <= $signed(res);
      saturated_o <= !fits;
    end
  end

  assign stat_o.n_zero     = (n_q == '0);
  assign stat_o.last_issue = (idx_q == n_q - CNT_W'(1));
  assign stat_o.pipe_busy  = rd_vld_q || mul_vld_q;
  assign stat_o.scale_last = (bit_q == '0);

endmodule

// ===== rtl/kernel_convolution_propagation_top.sv =====
// Top level of the kernel convolution propagation block: joins controller
// and datapath. Depends on kcp_pkg, kcp_ctrl and kcp_datapath.
`timescale 1ns / 1ps

// Usage: the input channel (in_valid_i/in_ready_o) carries one word that is
// either a coefficient load (req_type_i = 0, tap_index_i, coefficient_i) or a
// flow sample (req_type_i = 1, flow_sample_i). A load keeps the block idle
// and gives no result. A sample gives exactly one result word on the output
// channel (out_valid_o/out_ready_i): flow_out_o and saturated_o.
// The result word comes from n terms, where n is the smaller of active_taps
// and the number of earlier samples (at most 256). In order, the block runs
// one multiply-accumulate per tap through the single read port of each
// memory, drains that pipeline, does one shift-add per bit of the time step
// and loads the output register.
// No new word is taken until the current sample is finished, so the work on
// one sample never overlaps the work on the next.
// A finished result sits in the output register; if the receiver stalls,
// the next sample is still accepted and computed, then waits until the
// output register is free. Reset clears the sample count, the ring pointer
// and the output valid, and sets active_taps to 256 and time_step to 60; the
// kernel and history memories are not cleared, so load every tap in use
// before the first sample. Write cfg_we_i/cfg_index_i/cfg_wdata_i only while
// the block is idle.
module kernel_convolution_propagation_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kcp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [kcp_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [kcp_pkg::IDX_W-1:0]           tap_index_i,
  input  logic [kcp_pkg::COEF_W-1:0]          coefficient_i,
  input  logic signed [kcp_pkg::SAMPLE_W-1:0] flow_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [kcp_pkg::OUT_W-1:0]    flow_out_o,
  output logic                                saturated_o
);

  kcp_pkg::kcp_cmd_t  cmd;
  kcp_pkg::kcp_stat_t stat;

  kcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  kcp_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .tap_index_i   (tap_index_i),
    .coefficient_i (coefficient_i),
    .flow_sample_i (flow_sample_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .flow_out_o    (flow_out_o),
    .saturated_o   (saturated_o)
  );

endmodule

// ===== rtl/kcp_checker.sv =====
// Port-level checks of the kernel convolution block, bound to the top level.
// Depends on kcp_pkg and kernel_convolution_propagation_top.
`timescale 1ns / 1ps

module kcp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                req_type_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [kcp_pkg::OUT_W-1:0]    flow_out_o,
  input logic                                saturated_o
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(flow_out_o) &&
                                    $stable(saturated_o))
    else $error("result word changed while stalled");

  // A sample keeps the block busy for at least the following cycle.
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == kcp_pkg::REQ_SAMPLE) |=> !in_ready_o)
    else $error("input taken right after a sample");

  // A coefficient load never produces a result word.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == kcp_pkg::REQ_LOAD) && !out_valid_o
    |=> !out_valid_o)
    else $error("result after a coefficient load");

  // A clipped result is one of the two range limits.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (flow_out_o == $signed(kcp_pkg::OUT_MAX)) ||
                                   (flow_out_o == $signed(kcp_pkg::OUT_MIN)))
    else $error("saturated result is not a range limit");

endmodule

bind kernel_convolution_propagation_top kcp_checker u_kcp_checker (.*);

// ===== tb/sv/tb.sv =====
// Testbench for kernel_convolution_propagation_top: loads kernel taps, streams
// flow samples and checks each result word against a local convolution model.
// Depends on kcp_pkg and the kernel_convolution_propagation_top RTL.
`timescale 1ns / 1ps

module tb;
  import kcp_pkg::*;

  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 2000;

  localparam logic signed [95:0] FLOW_HI = 96'sh7FFF_FFFF;
  localparam logic signed [95:0] FLOW_LO = -96'sh8000_0000;

  typedef struct packed {
    logic signed [OUT_W-1:0] flow;
    logic                    sat;
  } flow_result_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i   = '0;
  logic [CFG_W-1:0]           cfg_wdata_i   = '0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_ready_o;
  logic                       req_type_i    = REQ_LOAD;
  logic [IDX_W-1:0]           tap_index_i   = '0;
  logic [COEF_W-1:0]          coefficient_i = '0;
  logic signed [SAMPLE_W-1:0] flow_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i   = 1'b0;
  logic signed [OUT_W-1:0]    flow_out_o;
  logic                       saturated_o;

  kernel_convolution_propagation_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .tap_index_i   (tap_index_i),
    .coefficient_i (coefficient_i),
    .flow_sample_i (flow_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .flow_out_o    (flow_out_o),
    .saturated_o   (saturated_o)
  );

  // Local copy of the block state.
  logic [COEF_W-1:0]          coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  int                         hist_count = 0;
  logic [TAP_W-1:0]           wr_ptr     = '0;
  logic [ACTIVE_W-1:0]        cfg_taps   = ACTIVE_RESET;
  logic [TS_W-1:0]            cfg_step   = TS_RESET;

  flow_result_t flow_expect_q[$];

  int  mismatches      = 0;
  int  results_checked = 0;
  int  words_sent      = 0;
  int  settings_used   = 1;
  int  burst_left      = 0;
  int  cycle_count     = 0;
  bit  hold_req        = 1'b0;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Exact convolution of the newest sample, floored to Q16.16 and clipped.
  function automatic flow_result_t propagate_flow();
    int                 lim;
    int                 n;
    int                 i;
    logic [TAP_W-1:0]   idx;
    logic signed [95:0] acc;
    logic signed [95:0] scaled;
    logic signed [95:0] q;
    flow_result_t       r;
    lim = (cfg_taps > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
    n   = (hist_count < lim) ? hist_count : lim;
    acc = '0;
    for (i = 0; i < n; i++) begin
      idx = wr_ptr - TAP_W'(i);
      acc = acc + $signed({1'b0, coef_mem[i]}) * hist_mem[idx];
    end
    scaled = acc * $signed({1'b0, cfg_step});
    q      = scaled >>> FRAC_DROP;
    if (q > FLOW_HI) begin
      r.flow = OUT_MAX;
      r.sat  = 1'b1;
    end else if (q < FLOW_LO) begin
      r.flow = OUT_MIN;
      r.sat  = 1'b1;
    end else begin
      r.flow = q[OUT_W-1:0];
      r.sat  = 1'b0;
    end
    return r;
  endfunction

  task automatic track_word(input logic req, input logic [IDX_W-1:0] tap,
                            input logic [COEF_W-1:0] coef,
                            input logic signed [SAMPLE_W-1:0] samp);
    if (req == REQ_LOAD) begin
      coef_mem[tap] = coef;
    end else begin
      hist_mem[wr_ptr] = samp;
      flow_expect_q.push_back(propagate_flow());
      if (hist_count < MAX_TAPS) hist_count++;
      wr_ptr = wr_ptr + TAP_W'(1);
    end
  endtask

  // Sends one word; bursts of random length with random gaps between them.
  task automatic send_word(input logic req, input logic [IDX_W-1:0] tap,
                           input logic [COEF_W-1:0] coef,
                           input logic signed [SAMPLE_W-1:0] samp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    tap_index_i   <= tap;
    coefficient_i <= coef;
    flow_sample_i <= samp;
    do @(posedge clk_i); while (!in_ready_o);
    track_word(req, tap, coef, samp);
    words_sent++;
  endtask

  function automatic logic [COEF_W-1:0] random_coef();
    logic [COEF_W-1:0] c;
    c = COEF_W'($urandom);
    if ($urandom_range(0, 9) == 0) c = '1;
    else c = c >> $urandom_range(0, COEF_W - 1);
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_flow();
    logic signed [SAMPLE_W-1:0] s;
    s = $urandom;
    case ($urandom_range(0, 15))
      0: s = 32'sh7FFF_FFFF;
      1: s = 32'sh8000_0000;
      2: s = '0;
      3: s = -32'sd1;
      default: s = s >>> $urandom_range(0, SAMPLE_W - 1);
    endcase
    return s;
  endfunction

  task automatic send_random_word();
    logic [IDX_W-1:0] tap;
    if ($urandom_range(0, 9) < 7) begin
      send_word(REQ_SAMPLE, IDX_W'($urandom), random_coef(), random_flow());
    end else begin
      tap = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 255))
                                 : IDX_W'($urandom_range(0, 15));
      send_word(REQ_LOAD, tap, random_coef(), random_flow());
    end
  endtask

  // Waits until the block is idle, so that registers may be written.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (flow_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [ACTIVE_W-1:0] taps,
                                input logic [TS_W-1:0] step);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ACTIVE_TAPS;
    cfg_wdata_i <= CFG_W'(taps);
    @(posedge clk_i);
    cfg_index_i <= REG_TIME_STEP;
    cfg_wdata_i <= step;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_taps = taps;
    cfg_step = step;
    settings_used++;
  endtask

  task automatic run_phase(input logic [ACTIVE_W-1:0] taps,
                           input logic [TS_W-1:0] step, input int words);
    settle();
    write_settings(taps, step);
    repeat (words) send_random_word();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h (result %0d, cycle %0d)",
             what, got, want, results_checked, cycle_count);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : result_check
    flow_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (flow_expect_q.size() == 0) begin
        report_mismatch("result word with none expected", flow_out_o, '0);
      end else begin
        want = flow_expect_q.pop_front();
        if (flow_out_o !== want.flow)
          report_mismatch("flow_out", flow_out_o, want.flow);
        if (saturated_o !== want.sat)
          report_mismatch("saturated", 32'(saturated_o), 32'(want.sat));
      end
      results_checked++;
    end
  end

  // Receiver: switches between stall patterns, or holds off on request.
  initial begin : receiver
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 200);
        end
        mode_left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Extremes of the fields at the reset register values.
  task automatic test_reset_values();
    send_word(REQ_LOAD, 8'd0,   24'hFF_FFFF, '0);
    send_word(REQ_LOAD, 8'd1,   24'h80_0000, '0);
    send_word(REQ_LOAD, 8'd2,   24'h00_0000, '0);
    send_word(REQ_LOAD, 8'd3,   24'h00_0001, '0);
    send_word(REQ_LOAD, 8'd4,   24'h40_0000, '0);
    send_word(REQ_LOAD, 8'd5,   24'h12_3456, '0);
    send_word(REQ_LOAD, 8'd255, 24'hFF_FFFF, '0);
    // The first sample has no history behind it and must give zero.
    send_word(REQ_SAMPLE, '0, '0, 32'sh7FFF_FFFF);
    send_word(REQ_SAMPLE, '0, '0, 32'sh8000_0000);
    send_word(REQ_SAMPLE, '0, '0, 32'sh0000_0000);
    send_word(REQ_SAMPLE, '0, '0, -32'sd1);
    send_word(REQ_SAMPLE, '0, '0, 32'sh0001_0000);
    send_word(REQ_SAMPLE, '0, '0, 32'sh7FFF_FFFF);
  endtask

  // Every tap gets loaded before any long convolution reads it.
  task automatic test_kernel_fill();
    int t;
    for (t = 0; t < MAX_TAPS; t++)
      send_word(REQ_LOAD, IDX_W'(t), random_coef(), '0);
  endtask

  task automatic test_register_sweep();
    logic [TS_W-1:0] step;
    run_phase(9'd4,   16'd60,     200);
    run_phase(9'd1,   16'hFFFF,   200);
    run_phase(9'd0,   16'd1,      80);
    run_phase(9'd16,  16'd0,      80);
    run_phase(9'd511, 16'd1,      50);
    run_phase(9'd256, 16'hFFFF,   50);
    run_phase(9'd2,   16'd60,     100);
    repeat (5) begin
      step = $urandom_range(0, 1) ? TS_W'($urandom_range(1, 255))
                                  : TS_W'($urandom_range(1, 65535));
      run_phase(ACTIVE_W'($urandom_range(1, 24)), step, 150);
    end
  endtask

  // The receiver holds off while samples keep coming, so the input stalls.
  task automatic test_output_backpressure();
    settle();
    write_settings(9'd8, 16'd60);
    hold_req = 1'b1;
    repeat (16) send_word(REQ_SAMPLE, '0, '0, random_flow());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_kernel_fill();
    test_register_sweep();
    test_output_backpressure();
    in_valid_i <= 1'b0;
    while (flow_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d words and checked %0d result words under %0d register settings,",
             words_sent, results_checked, settings_used);
    $display("including zero and over-range taps, zero and full time step, and a long output stall.");
    if (mismatches == 0 && flow_expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kcp_pkg.sv
rtl/kcp_ctrl.sv
rtl/kcp_datapath.sv
rtl/kernel_convolution_propagation_top.sv
rtl/kcp_checker.sv
tb/sv/tb.sv
